FILE: design/mcas_pkg.sv
package mcas_pkg;

  // Field widths of the item channels and the configuration port.
  localparam int OpW     = 2;
  localparam int CmdW    = 8;
  localparam int EchoW   = 15;
  localparam int DutyW   = 8;
  localparam int FbW     = 4;
  localparam int LimitW  = 10;
  localparam int HoldW   = 16;
  localparam int IdleW   = 17;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 16;

  // Item kinds.
  localparam logic [OpW-1:0] OP_CMD  = 2'd0;
  localparam logic [OpW-1:0] OP_TICK = 2'd1;
  localparam logic [OpW-1:0] OP_ECHO = 2'd2;

  // Command characters.
  localparam logic [CmdW-1:0] CMD_AUTO   = 8'h41;
  localparam logic [CmdW-1:0] CMD_MANUAL = 8'h4D;
  localparam logic [CmdW-1:0] CMD_FWD    = 8'h46;
  localparam logic [CmdW-1:0] CMD_BACK   = 8'h42;
  localparam logic [CmdW-1:0] CMD_LEFT   = 8'h4C;
  localparam logic [CmdW-1:0] CMD_RIGHT  = 8'h52;
  localparam logic [CmdW-1:0] CMD_STOP   = 8'h53;
  localparam logic [CmdW-1:0] CMD_SPD1   = 8'h31;
  localparam logic [CmdW-1:0] CMD_SPD2   = 8'h32;
  localparam logic [CmdW-1:0] CMD_SPD3   = 8'h33;
  localparam logic [CmdW-1:0] CMD_SPD4   = 8'h34;

  // Feedback codes.
  localparam logic [FbW-1:0] FB_NONE     = 4'd0;
  localparam logic [FbW-1:0] FB_AUTO     = 4'd1;
  localparam logic [FbW-1:0] FB_MANUAL   = 4'd2;
  localparam logic [FbW-1:0] FB_FWD      = 4'd3;
  localparam logic [FbW-1:0] FB_BACK     = 4'd4;
  localparam logic [FbW-1:0] FB_LEFT     = 4'd5;
  localparam logic [FbW-1:0] FB_RIGHT    = 4'd6;
  localparam logic [FbW-1:0] FB_STOP     = 4'd7;
  localparam logic [FbW-1:0] FB_SPD1     = 4'd8;
  localparam logic [FbW-1:0] FB_SPD2     = 4'd9;
  localparam logic [FbW-1:0] FB_SPD3     = 4'd10;
  localparam logic [FbW-1:0] FB_SPD4     = 4'd11;
  localparam logic [FbW-1:0] FB_OBSTACLE = 4'd12;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_OBSTACLE_LIMIT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_IDLE_TIMEOUT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_STOP_HOLD      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REVERSE_HOLD   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TURN_HOLD      = 3'd4;

  // Register reset values.
  localparam logic [LimitW-1:0] LIMIT_RST   = 10'd25;
  localparam logic [HoldW-1:0]  TIMEOUT_RST = 16'd1000;
  localparam logic [HoldW-1:0]  STOP_RST    = 16'd300;
  localparam logic [HoldW-1:0]  REVERSE_RST = 16'd500;
  localparam logic [HoldW-1:0]  TURN_RST    = 16'd600;

  // Speeds and distances.
  localparam logic [DutyW-1:0]  SPEED_RST  = 8'd180;
  localparam logic [DutyW-1:0]  SPEED1     = 8'd120;
  localparam logic [DutyW-1:0]  SPEED2     = 8'd160;
  localparam logic [DutyW-1:0]  SPEED3     = 8'd200;
  localparam logic [DutyW-1:0]  SPEED4     = 8'd255;
  localparam logic [LimitW-1:0] FAR_DIST   = 10'd300;
  localparam logic [EchoW-1:0]  ECHO_LIMIT = 15'd30000;
  localparam logic [IdleW-1:0]  IDLE_MAX   = 17'h1FFFF;
  localparam logic [HoldW-1:0]  PHASE_MAX  = 16'hFFFF;

  // Direction lines: {a_fwd, a_rev, b_fwd, b_rev}.
  localparam logic [3:0] DIR_FWD   = 4'b1010;
  localparam logic [3:0] DIR_BACK  = 4'b0101;
  localparam logic [3:0] DIR_LEFT  = 4'b0110;
  localparam logic [3:0] DIR_RIGHT = 4'b1001;

  // Avoid sequence phases.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_STOP    = 4'b0010,
    PH_REVERSE = 4'b0100,
    PH_TURN    = 4'b1000
  } phase_t;

endpackage

FILE: design/mcas_if.sv
interface mcas_in_if import mcas_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [CmdW-1:0]  command_byte;
  logic [EchoW-1:0] echo_us;

  modport source (output valid, output operation, output command_byte, output echo_us,
                  input ready);
  modport sink (input valid, input operation, input command_byte, input echo_us,
                output ready);
endinterface

interface mcas_out_if import mcas_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DutyW-1:0] duty_a;
  logic [DutyW-1:0] duty_b;
  logic             a_fwd;
  logic             a_rev;
  logic             b_fwd;
  logic             b_rev;
  logic             auto_active;
  logic             sequence_busy;
  logic [FbW-1:0]   feedback;

  modport source (output valid, output duty_a, output duty_b, output a_fwd, output a_rev,
                  output b_fwd, output b_rev, output auto_active, output sequence_busy,
                  output feedback, input ready);
  modport sink (input valid, input duty_a, input duty_b, input a_fwd, input a_rev,
                input b_fwd, input b_rev, input auto_active, input sequence_busy,
                input feedback, output ready);
endinterface

interface mcas_cfg_if import mcas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/motor_command_avoid_sequencer_unit.sv
// An item accepted from the input channel passes through the input register and then the
// result register, from which its result is offered on the output channel.
// Throughput: one item per cycle while results are taken; a result left waiting holds
// the result register, and once the input register also holds an item the input stalls.
// Reset (rst_n low at a clock edge) empties both registers, selects manual mode with
// motors stopped, speed 180, and loads the default configuration values.
module motor_command_avoid_sequencer_unit import mcas_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  mcas_in_if.sink    in_ch,
  mcas_out_if.source out_ch,
  mcas_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic [LimitW-1:0] limit_r;
  logic [HoldW-1:0]  timeout_r;
  logic [HoldW-1:0]  stop_hold_r;
  logic [HoldW-1:0]  rev_hold_r;
  logic [HoldW-1:0]  turn_hold_r;

  // Input register.
  logic             s1_valid_r;
  logic [OpW-1:0]   s1_op_r;
  logic [CmdW-1:0]  s1_cmd_r;
  logic [EchoW-1:0] s1_echo_r;

  // Controller state.
  logic             auto_r, auto_nxt;
  logic [DutyW-1:0] speed_r, speed_nxt;
  phase_t           phase_r, phase_nxt;
  logic [HoldW-1:0] pcnt_r, pcnt_nxt;
  logic [IdleW-1:0] idle_r, idle_nxt;
  logic [DutyW-1:0] duty_a_r, duty_a_nxt;
  logic [DutyW-1:0] duty_b_r, duty_b_nxt;
  logic [3:0]       dir_r, dir_nxt;
  logic [FbW-1:0]   fb_nxt;

  // Result register.
  logic             out_valid_r;
  logic [DutyW-1:0] out_duty_a_r;
  logic [DutyW-1:0] out_duty_b_r;
  logic [3:0]       out_dir_r;
  logic             out_auto_r;
  logic             out_busy_r;
  logic [FbW-1:0]   out_fb_r;

  logic advance;

  // The registered item moves into the result register whenever that register is empty
  // or its item is being taken in this cycle; the input register refills in the same cycle.
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RST;
      timeout_r   <= TIMEOUT_RST;
      stop_hold_r <= STOP_RST;
      rev_hold_r  <= REVERSE_RST;
      turn_hold_r <= TURN_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_OBSTACLE_LIMIT: limit_r     <= cfg_ch.data[LimitW-1:0];
        REG_IDLE_TIMEOUT:   timeout_r   <= cfg_ch.data;
        REG_STOP_HOLD:      stop_hold_r <= cfg_ch.data;
        REG_REVERSE_HOLD:   rev_hold_r  <= cfg_ch.data;
        REG_TURN_HOLD:      turn_hold_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r   <= in_ch.operation;
      s1_cmd_r  <= in_ch.command_byte;
      s1_echo_r <= in_ch.echo_us;
    end
  end

  // Obstacle test. Rather than dividing, floor(echo * 17 / 1000) <= limit is checked as
  // echo * 17 < (limit + 1) * 1000; both products are by constants.
  logic [19:0] echo_scaled;
  logic [20:0] limit_scaled;
  logic        echo_far;
  logic        obstacle_near;

  assign echo_scaled   = {5'd0, s1_echo_r} * 20'd17;
  assign limit_scaled  = ({11'd0, limit_r} + 21'd1) * 21'd1000;
  assign echo_far      = (s1_echo_r == '0) || (s1_echo_r > ECHO_LIMIT);
  assign obstacle_near = echo_far ? (FAR_DIST <= limit_r)
                                  : ({1'b0, echo_scaled} < limit_scaled);

  logic [DutyW-1:0] half_speed;
  logic [HoldW-1:0] pcnt_inc;
  logic [IdleW-1:0] idle_inc;
  logic [HoldW-1:0] hold_sel;

  assign half_speed = {1'b0, speed_r[DutyW-1:1]};
  assign pcnt_inc   = (pcnt_r == PHASE_MAX) ? pcnt_r : pcnt_r + 16'd1;
  assign idle_inc   = (idle_r == IDLE_MAX) ? idle_r : idle_r + 17'd1;

  always_comb begin
    case (phase_r)
      PH_STOP:    hold_sel = stop_hold_r;
      PH_REVERSE: hold_sel = rev_hold_r;
      default:    hold_sel = turn_hold_r;
    endcase
  end

  always_comb begin
    auto_nxt   = auto_r;
    speed_nxt  = speed_r;
    phase_nxt  = phase_r;
    pcnt_nxt   = pcnt_r;
    idle_nxt   = idle_r;
    duty_a_nxt = duty_a_r;
    duty_b_nxt = duty_b_r;
    dir_nxt    = dir_r;
    fb_nxt     = FB_NONE;

    case (s1_op_r)
      OP_CMD: begin
        // Commands are dropped while the avoid sequence runs.
        if (phase_r == PH_IDLE) begin
          idle_nxt = '0;
          if (s1_cmd_r == CMD_AUTO) begin
            auto_nxt = 1'b1;
            fb_nxt   = FB_AUTO;
          end else if (s1_cmd_r == CMD_MANUAL) begin
            auto_nxt = 1'b0;
            fb_nxt   = FB_MANUAL;
          end else if (!auto_r) begin
            case (s1_cmd_r)
              CMD_FWD: begin
                duty_a_nxt = speed_r;
                duty_b_nxt = speed_r;
                dir_nxt    = DIR_FWD;
                fb_nxt     = FB_FWD;
              end
              CMD_BACK: begin
                duty_a_nxt = speed_r;
                duty_b_nxt = speed_r;
                dir_nxt    = DIR_BACK;
                fb_nxt     = FB_BACK;
              end
              CMD_LEFT: begin
                duty_a_nxt = half_speed;
                duty_b_nxt = speed_r;
                dir_nxt    = DIR_LEFT;
                fb_nxt     = FB_LEFT;
              end
              CMD_RIGHT: begin
                duty_a_nxt = speed_r;
                duty_b_nxt = half_speed;
                dir_nxt    = DIR_RIGHT;
                fb_nxt     = FB_RIGHT;
              end
              CMD_STOP: begin
                duty_a_nxt = '0;
                duty_b_nxt = '0;
                fb_nxt     = FB_STOP;
              end
              CMD_SPD1: begin
                speed_nxt = SPEED1;
                fb_nxt    = FB_SPD1;
              end
              CMD_SPD2: begin
                speed_nxt = SPEED2;
                fb_nxt    = FB_SPD2;
              end
              CMD_SPD3: begin
                speed_nxt = SPEED3;
                fb_nxt    = FB_SPD3;
              end
              CMD_SPD4: begin
                speed_nxt = SPEED4;
                fb_nxt    = FB_SPD4;
              end
              default: begin
              end
            endcase
          end
        end
      end
      OP_TICK: begin
        idle_nxt = idle_inc;
        if (phase_r != PH_IDLE) begin
          pcnt_nxt = pcnt_inc;
          if (pcnt_inc >= hold_sel) begin
            // Phase ends: reverse after the stop, turn left after the reverse, and
            // drive forward with the obstacle report once the turn is done.
            pcnt_nxt = '0;
            case (phase_r)
              PH_STOP: begin
                duty_a_nxt = speed_r;
                duty_b_nxt = speed_r;
                dir_nxt    = DIR_BACK;
                phase_nxt  = PH_REVERSE;
              end
              PH_REVERSE: begin
                duty_a_nxt = half_speed;
                duty_b_nxt = speed_r;
                dir_nxt    = DIR_LEFT;
                phase_nxt  = PH_TURN;
              end
              default: begin
                duty_a_nxt = speed_r;
                duty_b_nxt = speed_r;
                dir_nxt    = DIR_FWD;
                phase_nxt  = PH_IDLE;
                fb_nxt     = FB_OBSTACLE;
              end
            endcase
          end
        end else if (!auto_r && (idle_inc > {1'b0, timeout_r})) begin
          // Manual mode idle stop; the direction lines are left as they are.
          duty_a_nxt = '0;
          duty_b_nxt = '0;
        end
      end
      OP_ECHO: begin
        if (phase_r == PH_IDLE && auto_r) begin
          if (obstacle_near) begin
            duty_a_nxt = '0;
            duty_b_nxt = '0;
            phase_nxt  = PH_STOP;
            pcnt_nxt   = '0;
          end else begin
            duty_a_nxt = speed_r;
            duty_b_nxt = speed_r;
            dir_nxt    = DIR_FWD;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r   <= 1'b0;
      speed_r  <= SPEED_RST;
      phase_r  <= PH_IDLE;
      pcnt_r   <= '0;
      idle_r   <= '0;
      duty_a_r <= '0;
      duty_b_r <= '0;
      dir_r    <= '0;
    end else if (advance) begin
      auto_r   <= auto_nxt;
      speed_r  <= speed_nxt;
      phase_r  <= phase_nxt;
      pcnt_r   <= pcnt_nxt;
      idle_r   <= idle_nxt;
      duty_a_r <= duty_a_nxt;
      duty_b_r <= duty_b_nxt;
      dir_r    <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_duty_a_r <= duty_a_nxt;
      out_duty_b_r <= duty_b_nxt;
      out_dir_r    <= dir_nxt;
      out_auto_r   <= auto_nxt;
      out_busy_r   <= (phase_nxt != PH_IDLE);
      out_fb_r     <= fb_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.duty_a        = out_duty_a_r;
  assign out_ch.duty_b        = out_duty_b_r;
  assign out_ch.a_fwd         = out_dir_r[3];
  assign out_ch.a_rev         = out_dir_r[2];
  assign out_ch.b_fwd         = out_dir_r[1];
  assign out_ch.b_rev         = out_dir_r[0];
  assign out_ch.auto_active   = out_auto_r;
  assign out_ch.sequence_busy = out_busy_r;
  assign out_ch.feedback      = out_fb_r;

endmodule

FILE: design/mcas_checker.sv
module mcas_checker import mcas_pkg::*; (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input logic           a_fwd,
  input logic           a_rev,
  input logic           auto_active,
  input logic           sequence_busy,
  input logic [FbW-1:0] feedback
);

  // A result left untaken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // The avoid sequence only ever runs in auto mode.
  a_busy_auto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sequence_busy |-> auto_active)
    else $error("sequence running outside auto mode");

  // The obstacle report marks the end of the sequence.
  a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && feedback == FB_OBSTACLE |-> !sequence_busy && auto_active)
    else $error("obstacle report while sequence still running");

  // Motor A is never driven both ways.
  a_dir_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(a_fwd && a_rev))
    else $error("motor A direction lines both high");

endmodule

bind motor_command_avoid_sequencer_unit mcas_checker u_mcas_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .a_fwd         (out_ch.a_fwd),
  .a_rev         (out_ch.a_rev),
  .auto_active   (out_ch.auto_active),
  .sequence_busy (out_ch.sequence_busy),
  .feedback      (out_ch.feedback)
);
